/* rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; every macro samples on the rising edge of clk_i, gated by rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies the consequent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/llex_pkg.sv */
// types, codes and character classes of the lisp token lexer
// no dependencies
`default_nettype none

package llex_pkg;

  // lexer modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_QUOTE  = 3'd1;
  localparam logic [2:0] MODE_HASH   = 3'd2;
  localparam logic [2:0] MODE_CMP    = 3'd3;
  localparam logic [2:0] MODE_NUMBER = 3'd4;
  localparam logic [2:0] MODE_SYMBOL = 3'd5;
  localparam logic [2:0] MODE_STRING = 3'd6;

  // token kinds
  localparam logic [3:0] KIND_SKIP   = 4'd0;
  localparam logic [3:0] KIND_OPEN   = 4'd1;
  localparam logic [3:0] KIND_CLOSE  = 4'd2;
  localparam logic [3:0] KIND_QUOTE  = 4'd3;
  localparam logic [3:0] KIND_QOPEN  = 4'd4;
  localparam logic [3:0] KIND_BOOL   = 4'd5;
  localparam logic [3:0] KIND_CMP    = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_SYMBOL = 4'd8;
  localparam logic [3:0] KIND_STRING = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_INVALID  = 3'd1;
  localparam logic [2:0] ERR_BAD_HASH = 3'd2;
  localparam logic [2:0] ERR_HASH_END = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [2:0] mode;
    logic [7:0] hbyte;
    logic [3:0] kind;
    logic       first;
    logic [2:0] err;
  } llex_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] kind;
    logic       first;
    logic       last;
    logic [2:0] err;
    logic       run_last;
  } llex_res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic num_char(logic [7:0] c);
    return is_digit(c) || (c == 8'h2e);
  endfunction

  function automatic logic sym_start(logic [7:0] c);
    return is_alpha(c) || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) ||
           (c == 8'h2f) || (c == 8'h3f);
  endfunction

  function automatic logic sym_more(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == 8'h5f) || (c == 8'h2d) || (c == 8'h3f);
  endfunction

  function automatic llex_state_t hold(logic [7:0] c, logic [3:0] kind, logic first,
                                       logic [2:0] err, logic [2:0] mode);
    llex_state_t s;
    s.valid = 1'b1;
    s.mode  = mode;
    s.hbyte = c;
    s.kind  = kind;
    s.first = first;
    s.err   = err;
    return s;
  endfunction

  // classification of a byte that opens a new token
  function automatic llex_state_t start_token(logic [7:0] c);
    llex_state_t s;
    if (is_space(c))                   s = hold(c, KIND_SKIP, 1'b0, ERR_NONE, MODE_IDLE);
    else if (c == 8'h27)               s = hold(c, KIND_QUOTE, 1'b1, ERR_NONE, MODE_QUOTE);
    else if (c == 8'h28)               s = hold(c, KIND_OPEN, 1'b1, ERR_NONE, MODE_IDLE);
    else if (c == 8'h29)               s = hold(c, KIND_CLOSE, 1'b1, ERR_NONE, MODE_IDLE);
    else if (c == 8'h23)               s = hold(c, KIND_BOOL, 1'b1, ERR_NONE, MODE_HASH);
    else if (c == 8'h3c || c == 8'h3e) s = hold(c, KIND_CMP, 1'b1, ERR_NONE, MODE_CMP);
    else if (c == 8'h3d)               s = hold(c, KIND_CMP, 1'b1, ERR_NONE, MODE_IDLE);
    else if (num_char(c))              s = hold(c, KIND_NUMBER, 1'b1, ERR_NONE, MODE_NUMBER);
    else if (sym_start(c))             s = hold(c, KIND_SYMBOL, 1'b1, ERR_NONE, MODE_SYMBOL);
    else if (c == 8'h22)               s = hold(c, KIND_STRING, 1'b1, ERR_NONE, MODE_STRING);
    else                               s = hold(c, KIND_SKIP, 1'b0, ERR_INVALID, MODE_IDLE);
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/llex_in_if.sv */
// input channel of the lexer: one source byte per transaction
// no dependencies
`default_nettype none

interface llex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

/* rtl/llex_out_if.sv */
// output channel of the lexer: one annotated byte per transaction
// no dependencies
`default_nettype none

interface llex_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] token_kind;
  logic       token_first;
  logic       token_last;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output token_kind, output token_first,
                  output token_last, output error_code, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input token_kind, input token_first,
                  input token_last, input error_code, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/llex_step.sv */
// one lexer step: next state and up to two annotations from the held state and a byte
// depends on llex_pkg
`default_nettype none

module llex_step import llex_pkg::*; (
  input  llex_state_t st_i,
  input  logic [7:0]  c_i,
  input  logic        eoi_i,
  output llex_state_t st_o,
  output llex_res_t   held_res_o,
  output llex_res_t   flush_res_o
);

  llex_state_t s1;
  llex_res_t   r0;
  llex_res_t   r1;
  logic        fresh;
  logic [3:0]  ck;
  logic [2:0]  cmode;

  always_comb begin
    r0.data     = st_i.hbyte;
    r0.kind     = st_i.kind;
    r0.first    = st_i.first;
    r0.last     = 1'b0;
    r0.err      = st_i.err;
    r0.run_last = !eoi_i;
    fresh = 1'b1;
    ck    = KIND_SKIP;
    cmode = MODE_IDLE;
    unique case (st_i.mode)
      MODE_QUOTE: begin
        if (c_i == 8'h28) begin
          r0.kind = KIND_QOPEN;
          fresh   = 1'b0;
          ck      = KIND_QOPEN;
        end else begin
          r0.last = 1'b1;
        end
      end
      MODE_HASH: begin
        if (c_i == 8'h74 || c_i == 8'h66) begin
          fresh = 1'b0;
          ck    = KIND_BOOL;
        end else begin
          r0.kind  = KIND_SKIP;
          r0.first = 1'b0;
          r0.err   = ERR_BAD_HASH;
        end
      end
      MODE_CMP: begin
        if (c_i == 8'h3d) begin
          fresh = 1'b0;
          ck    = KIND_CMP;
        end else begin
          r0.last = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (num_char(c_i)) begin
          fresh = 1'b0;
          ck    = KIND_NUMBER;
          cmode = MODE_NUMBER;
        end else begin
          r0.last = 1'b1;
        end
      end
      MODE_SYMBOL: begin
        if (sym_more(c_i)) begin
          fresh = 1'b0;
          ck    = KIND_SYMBOL;
          cmode = MODE_SYMBOL;
        end else begin
          r0.last = 1'b1;
        end
      end
      MODE_STRING: begin
        fresh = 1'b0;
        ck    = KIND_STRING;
        cmode = (c_i == 8'h22) ? MODE_IDLE : MODE_STRING;
      end
      default: begin
        r0.last = (st_i.kind != KIND_SKIP);
      end
    endcase

    // with nothing held the byte always starts afresh
    if (!st_i.valid || fresh) s1 = start_token(c_i);
    else                      s1 = hold(c_i, ck, 1'b0, ERR_NONE, cmode);

    // flush of the byte just taken, used at end of input
    r1.data     = s1.hbyte;
    r1.kind     = s1.kind;
    r1.first    = s1.first;
    r1.last     = 1'b1;
    r1.err      = s1.err;
    r1.run_last = 1'b1;
    unique case (s1.mode)
      MODE_HASH: begin
        r1.kind  = KIND_SKIP;
        r1.first = 1'b0;
        r1.err   = ERR_HASH_END;
        r1.last  = 1'b0;
      end
      MODE_QUOTE, MODE_CMP, MODE_NUMBER, MODE_SYMBOL: r1.last = 1'b1;
      MODE_STRING: r1.err = ERR_OPEN_STR;
      default: r1.last = (s1.kind != KIND_SKIP);
    endcase

    if (eoi_i) st_o = '0;
    else       st_o = s1;
  end

  assign held_res_o  = r0;
  assign flush_res_o = r1;

endmodule

`default_nettype wire

/* rtl/lisp_token_lexer_top.sv */
// Streaming lexer for a small Lisp dialect. Each source byte is annotated with its token kind,
// first and last marks and an error code, one byte late: the annotation of a byte leaves once
// the following byte is seen, or at once when end_of_input is set; such a transaction yields
// two annotations (the held byte and the final byte) when a byte is held. A byte is taken in
// every cycle while annotations drain at the same pace; a transaction that yields two
// annotations fills the two-entry output register and holds off the input until the first drains.
// Depends on llex_pkg, llex_in_if, llex_out_if and llex_step.
`default_nettype none

module lisp_token_lexer_top import llex_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  llex_in_if.sink     in_ch,
  llex_out_if.source  out_ch
);

  llex_state_t st_q, st_d;
  llex_res_t   held_res, flush_res;
  llex_res_t   a_q, a_d, b_q, b_d;
  logic        a_vld_q, a_vld_d, b_vld_q, b_vld_d;
  logic        in_acc, out_pop;

  llex_step u_step (
    .st_i        (st_q),
    .c_i         (in_ch.in_byte),
    .eoi_i       (in_ch.end_of_input),
    .st_o        (st_d),
    .held_res_o  (held_res),
    .flush_res_o (flush_res)
  );

  // the second slot must be empty and the first one free by the next edge
  assign in_ch.ready = !b_vld_q && (!a_vld_q || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_pop     = a_vld_q && out_ch.ready;

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    a_vld_d = a_vld_q && !out_pop;
    b_vld_d = b_vld_q;
    if (in_acc) begin
      a_d     = st_q.valid ? held_res : flush_res;
      a_vld_d = st_q.valid || in_ch.end_of_input;
      b_d     = flush_res;
      b_vld_d = st_q.valid && in_ch.end_of_input;
    end else if (out_pop) begin
      a_d     = b_q;
      a_vld_d = b_vld_q;
      b_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (in_acc) st_q <= st_d;
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign out_ch.valid       = a_vld_q;
  assign out_ch.out_byte    = a_q.data;
  assign out_ch.token_kind  = a_q.kind;
  assign out_ch.token_first = a_q.first;
  assign out_ch.token_last  = a_q.last;
  assign out_ch.error_code  = a_q.err;
  assign out_ch.last_of_run = a_q.run_last;

endmodule

`default_nettype wire

/* rtl/llex_checker.sv */
// port-level checks of the lisp token lexer, bound to the top level
// depends on assert_macros.svh and llex_pkg
`default_nettype none
`include "assert_macros.svh"

module llex_checker import llex_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       in_eoi_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [3:0] out_kind_i,
  input wire       out_first_i,
  input wire [2:0] out_err_i
);

  `ASSERT_NEXT(a_stall_holds, out_valid_i && !out_ready_i, out_valid_i, "output dropped")
  `ASSERT_NEXT(a_eoi_yields, in_valid_i && in_ready_i && in_eoi_i, out_valid_i,
               "end of input without annotation")
  `ASSERT_SAME(a_first_kind, out_valid_i && out_first_i, out_kind_i != KIND_SKIP,
               "token start with skipped kind")
  `ASSERT_SAME(a_invalid_skip, out_valid_i && out_err_i == ERR_INVALID,
               out_kind_i == KIND_SKIP, "invalid byte carries a token kind")

endmodule

bind lisp_token_lexer_top llex_checker u_llex_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_eoi_i    (in_ch.end_of_input),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_kind_i  (out_ch.token_kind),
  .out_first_i (out_ch.token_first),
  .out_err_i   (out_ch.error_code)
);

`default_nettype wire
